@@ hdl/albe_pkg.sv @@
// Shared types and constants for the addressable LED bit encoder.
// No dependencies; used by every module in hdl/.
`default_nettype none

package albe_pkg;

  localparam int unsigned BITS_PER_PIXEL = 24;
  localparam int unsigned CNT_W          = 5;
  localparam int unsigned CFG_ADDR_W     = 3;
  localparam int unsigned CFG_DATA_W     = 8;
  localparam int unsigned PROD_W         = 15;   // 8-bit colour times 7-bit brightness
  localparam int unsigned RECIP_W        = 13;
  localparam int unsigned RECIP_SHIFT    = 19;

  // floor(x / 100) == (x * 5243) >> 19 for every x up to 255 * 100
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

  localparam logic [6:0] BRIGHT_MAX   = 7'd100;
  localparam logic [6:0] BRIGHT_RST   = 7'd50;
  localparam logic [7:0] ZERO_CODE_RST = 8'd33;
  localparam logic [7:0] ONE_CODE_RST  = 8'd66;
  localparam logic [7:0] RESET_SLOTS_RST = 8'd50;
  localparam logic [7:0] LED_COUNT_RST  = 8'd20;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_BRIGHTNESS  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_CODE   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ONE_CODE    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RESET_SLOTS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LED_COUNT   = 3'd4;

  // serialiser slot positions
  localparam logic [CNT_W-1:0] SLOT_LAST_BIT = 5'd23;
  localparam logic [CNT_W-1:0] SLOT_RESET    = 5'd24;

  // scaled pixel handed from the scaling pipe to the serialiser
  typedef struct packed {
    logic [BITS_PER_PIXEL-1:0] grb;
    logic                      has_reset;
  } pix_word_t;

  // line codes used by the serialiser
  typedef struct packed {
    logic [7:0] zero_code;
    logic [7:0] one_code;
    logic [7:0] reset_slots;
  } line_codes_t;

endpackage

`default_nettype wire

@@ hdl/albe_scale.sv @@
// Scaling pipe: index filter and colour multiply, then divide by 100.
// Two register stages; depends on albe_pkg.
`default_nettype none

module albe_scale (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              pix_valid,
  output logic                   pix_ready,
  input  wire logic [7:0]        pix_index,
  input  wire logic [7:0]        red,
  input  wire logic [7:0]        green,
  input  wire logic [7:0]        blue,
  input  wire logic [6:0]        brightness,
  input  wire logic [7:0]        led_count,
  input  wire logic [7:0]        reset_slots,
  output logic                   word_valid,
  input  wire logic              word_ready,
  output albe_pkg::pix_word_t    word
);

  // stage A: products
  logic                             a_valid_r;
  logic [albe_pkg::PROD_W-1:0]      a_prod_r_r, a_prod_g_r, a_prod_b_r;
  logic                             a_has_reset_r;
  // stage B: quotients
  logic                             b_valid_r;
  logic [7:0]                       b_r_r, b_g_r, b_b_r;
  logic                             b_has_reset_r;

  logic                             keep;
  logic                             ends_frame;
  logic                             a_ready;
  logic                             a_to_b;
  logic [albe_pkg::PROD_W+albe_pkg::RECIP_W-1:0] q_r, q_g, q_b;

  assign keep       = pix_index < led_count;
  assign ends_frame = ({1'b0, pix_index} + 9'd1) == {1'b0, led_count};

  assign a_to_b    = a_valid_r && (!b_valid_r || word_ready);
  assign a_ready   = !a_valid_r || a_to_b;
  assign pix_ready = a_ready;

  assign q_r = {{albe_pkg::RECIP_W{1'b0}}, a_prod_r_r} *
               {{albe_pkg::PROD_W{1'b0}}, albe_pkg::RECIP_100};
  assign q_g = {{albe_pkg::RECIP_W{1'b0}}, a_prod_g_r} *
               {{albe_pkg::PROD_W{1'b0}}, albe_pkg::RECIP_100};
  assign q_b = {{albe_pkg::RECIP_W{1'b0}}, a_prod_b_r} *
               {{albe_pkg::PROD_W{1'b0}}, albe_pkg::RECIP_100};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= pix_valid && keep;
      end
      if (!b_valid_r || word_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_prod_r_r    <= {7'd0, red}   * {8'd0, brightness};
      a_prod_g_r    <= {7'd0, green} * {8'd0, brightness};
      a_prod_b_r    <= {7'd0, blue}  * {8'd0, brightness};
      a_has_reset_r <= ends_frame && (reset_slots != 8'd0);
    end
    if (!b_valid_r || word_ready) begin
      b_r_r         <= q_r[albe_pkg::RECIP_SHIFT +: 8];
      b_g_r         <= q_g[albe_pkg::RECIP_SHIFT +: 8];
      b_b_r         <= q_b[albe_pkg::RECIP_SHIFT +: 8];
      b_has_reset_r <= a_has_reset_r;
    end
  end

  assign word_valid     = b_valid_r;
  assign word.grb       = {b_g_r, b_r_r, b_b_r};
  assign word.has_reset = b_has_reset_r;

endmodule

`default_nettype wire

@@ hdl/albe_serial.sv @@
// Bit serialiser and output register: one slot result per cycle while the receiver keeps res_ready high.
// Depends on albe_pkg.
`default_nettype none

module albe_serial (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  word_valid,
  output logic                       word_ready,
  input  wire albe_pkg::pix_word_t   word,
  input  wire albe_pkg::line_codes_t codes,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output logic [7:0]                 res_duty,
  output logic [7:0]                 res_slots,
  output logic                       res_frame_end,
  output logic                       res_last
);

  logic                                ser_valid_r;
  logic [albe_pkg::BITS_PER_PIXEL-1:0] ser_word_r;
  logic [albe_pkg::CNT_W-1:0]          ser_cnt_r;
  logic                                ser_has_reset_r;

  logic                                out_valid_r;
  logic [7:0]                          out_duty_r;
  logic [7:0]                          out_slots_r;
  logic                                out_frame_end_r;
  logic                                out_last_r;

  logic                                is_reset_slot;
  logic                                ser_last;
  logic                                out_load;
  logic                                ser_take;
  logic [7:0]                          slot_duty;

  assign is_reset_slot = ser_cnt_r == albe_pkg::SLOT_RESET;
  assign ser_last      = is_reset_slot ||
                         (ser_cnt_r == albe_pkg::SLOT_LAST_BIT && !ser_has_reset_r);
  assign out_load      = ser_valid_r && (!out_valid_r || res_ready);
  assign ser_take      = word_valid && (!ser_valid_r || (out_load && ser_last));
  assign word_ready    = !ser_valid_r || (out_load && ser_last);

  always_comb begin
    if (is_reset_slot) begin
      slot_duty = 8'd0;
    end else if (ser_word_r[albe_pkg::BITS_PER_PIXEL-1]) begin
      slot_duty = codes.one_code;
    end else begin
      slot_duty = codes.zero_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ser_take) begin
        ser_valid_r <= 1'b1;
      end else if (out_load && ser_last) begin
        ser_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      ser_word_r      <= word.grb;
      ser_has_reset_r <= word.has_reset;
      ser_cnt_r       <= '0;
    end else if (out_load) begin
      // advance to the next bit, MSB first
      ser_word_r <= {ser_word_r[albe_pkg::BITS_PER_PIXEL-2:0], 1'b0};
      ser_cnt_r  <= ser_cnt_r + 5'd1;
    end
    if (out_load) begin
      out_duty_r      <= slot_duty;
      out_slots_r     <= is_reset_slot ? codes.reset_slots : 8'd1;
      out_frame_end_r <= is_reset_slot;
      out_last_r      <= ser_last;
    end
  end

  assign res_valid     = out_valid_r;
  assign res_duty      = out_duty_r;
  assign res_slots     = out_slots_r;
  assign res_frame_end = out_frame_end_r;
  assign res_last      = out_last_r;

endmodule

`default_nettype wire

@@ hdl/addressable_led_bit_encoder.sv @@
// Top level of the addressable LED bit encoder: configuration registers,
// scaling pipe and serialiser. Depends on albe_pkg, albe_scale, albe_serial.
//
// Use: one request on the in_ channel is one pixel (LED index, red, green,
// blue). A pixel whose index is at or beyond led_count is taken and dropped.
// Every kept pixel is scaled by brightness (floor(c * brightness / 100)) and
// sent as 24 slot requests on the out_ channel, green, red, blue, MSB first,
// each with duty one_code or zero_code and slot count 1. The pixel at index
// led_count-1 adds a 25th request: duty 0 for reset_slots slots, with
// frame_end set (left out when reset_slots is 0). tlast marks the final
// request of each pixel.
// The edge that takes a pixel loads the multiply stage; the divide-by-100
// stage, the serialiser and the output register then load in that order.
// Throughput: one slot request per cycle while out_tready is high; the
// serialiser emits one bit a cycle and so sets the pace at which pixels
// are taken. Pixels queue in the two scaling stages while the serialiser works.
// Stall: when out_tready is low the output register holds its request and
// back-pressure reaches in_tready; nothing is lost or repeated.
// Reset (rst_n low, synchronous): empty the pipe, load default registers.
// Write configuration only while the block is idle.
`default_nettype none

module addressable_led_bit_encoder (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [albe_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [albe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // pixel input
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [31:0]                     in_tdata,  // pix_index, red, green, blue
  // slot results
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [15:0]                          out_tdata, // duty, slot_count
  output logic                                 out_tuser, // frame_end
  output logic                                 out_tlast
);

  logic [6:0] brightness_r;
  logic [7:0] zero_code_r;
  logic [7:0] one_code_r;
  logic [7:0] reset_slots_r;
  logic [7:0] led_count_r;

  logic                  word_valid;
  logic                  word_ready;
  albe_pkg::pix_word_t   word;
  albe_pkg::line_codes_t codes;

  // Register writes; a brightness whose low 7 bits exceed 100 is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r  <= albe_pkg::BRIGHT_RST;
      zero_code_r   <= albe_pkg::ZERO_CODE_RST;
      one_code_r    <= albe_pkg::ONE_CODE_RST;
      reset_slots_r <= albe_pkg::RESET_SLOTS_RST;
      led_count_r   <= albe_pkg::LED_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        albe_pkg::REG_BRIGHTNESS: begin
          if (cfg_wdata[6:0] <= albe_pkg::BRIGHT_MAX) begin
            brightness_r <= cfg_wdata[6:0];
          end
        end
        albe_pkg::REG_ZERO_CODE:   zero_code_r   <= cfg_wdata;
        albe_pkg::REG_ONE_CODE:    one_code_r    <= cfg_wdata;
        albe_pkg::REG_RESET_SLOTS: reset_slots_r <= cfg_wdata;
        albe_pkg::REG_LED_COUNT:   led_count_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign codes.zero_code   = zero_code_r;
  assign codes.one_code    = one_code_r;
  assign codes.reset_slots = reset_slots_r;

  albe_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_valid   (in_tvalid),
    .pix_ready   (in_tready),
    .pix_index   (in_tdata[7:0]),
    .red         (in_tdata[15:8]),
    .green       (in_tdata[23:16]),
    .blue        (in_tdata[31:24]),
    .brightness  (brightness_r),
    .led_count   (led_count_r),
    .reset_slots (reset_slots_r),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .word        (word)
  );

  albe_serial u_serial (
    .clk           (clk),
    .rst_n         (rst_n),
    .word_valid    (word_valid),
    .word_ready    (word_ready),
    .word          (word),
    .codes         (codes),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res_duty      (out_tdata[7:0]),
    .res_slots     (out_tdata[15:8]),
    .res_frame_end (out_tuser),
    .res_last      (out_tlast)
  );

`ifndef SYNTHESIS
  // the reset-period request closes the pixel and carries the latch length
  a_reset_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata[7:0] == 8'd0 &&
                                out_tdata[15:8] == reset_slots_r)
    else $error("reset slot request malformed");

  // every data bit lasts exactly one slot and uses one of the two codes
  a_data_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[15:8] == 8'd1 &&
      (out_tdata[7:0] == zero_code_r || out_tdata[7:0] == one_code_r))
    else $error("data slot request malformed");

  // brightness never holds a value above full scale
  a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
    brightness_r <= albe_pkg::BRIGHT_MAX)
    else $error("brightness out of range");
`endif

endmodule

`default_nettype wire

@@ tb/led_bit_checker.sv @@
// Scoreboard for the addressable LED bit encoder: tracks register writes,
// predicts slot requests per pixel and compares them with the out_ channel.
// Depends on albe_pkg for register indexes and reset values.
`timescale 1ns / 100ps

module led_bit_checker
  import albe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [31:0]           in_tdata,   // pix_index, red, green, blue
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [15:0]           out_tdata,  // duty, slot_count
  input  logic                  out_tuser,  // frame_end
  input  logic                  out_tlast,
  output int                    mismatches,
  output int                    slots_owed
);

  typedef struct packed {
    logic [7:0] duty;
    logic [7:0] slot_count;
    logic       frame_end;
    logic       last;
  } slot_req_t;

  slot_req_t  owed_slots[$];

  logic [6:0] brightness;
  logic [7:0] zero_code;
  logic [7:0] one_code;
  logic [7:0] reset_slots;
  logic [7:0] led_count;

  initial begin
    mismatches = 0;
    slots_owed = 0;
  end

  function automatic logic [7:0] dim_colour(input logic [7:0] c);
    int unsigned prod;
    prod = c * brightness;
    return 8'(prod / 100);
  endfunction

  // Expand one pixel into its slot requests, green-red-blue, MSB first.
  task automatic encode_pixel(input logic [31:0] px);
    logic [7:0]  idx;
    logic [23:0] grb;
    logic        closes_frame;
    slot_req_t   s;
    idx = px[7:0];
    if (idx >= led_count) return;
    closes_frame = (int'(idx) + 1 == int'(led_count)) && (reset_slots != 8'd0);
    grb = {dim_colour(px[23:16]), dim_colour(px[15:8]), dim_colour(px[31:24])};
    for (int i = 23; i >= 0; i--) begin
      s.duty       = grb[i] ? one_code : zero_code;
      s.slot_count = 8'd1;
      s.frame_end  = 1'b0;
      s.last       = (i == 0) && !closes_frame;
      owed_slots.push_back(s);
    end
    if (closes_frame) begin
      s = '{duty: 8'd0, slot_count: reset_slots, frame_end: 1'b1, last: 1'b1};
      owed_slots.push_back(s);
    end
  endtask

  always @(posedge clk) begin : watch
    slot_req_t got;
    slot_req_t want;
    if (!rst_n) begin
      brightness  = BRIGHT_RST;
      zero_code   = ZERO_CODE_RST;
      one_code    = ONE_CODE_RST;
      reset_slots = RESET_SLOTS_RST;
      led_count   = LED_COUNT_RST;
      owed_slots.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_BRIGHTNESS:  if (cfg_wdata[6:0] <= BRIGHT_MAX) brightness = cfg_wdata[6:0];
          REG_ZERO_CODE:   zero_code   = cfg_wdata;
          REG_ONE_CODE:    one_code    = cfg_wdata;
          REG_RESET_SLOTS: reset_slots = cfg_wdata;
          REG_LED_COUNT:   led_count   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) encode_pixel(in_tdata);
      if (out_tvalid && out_tready) begin
        got = '{duty: out_tdata[7:0], slot_count: out_tdata[15:8],
                frame_end: out_tuser, last: out_tlast};
        if (owed_slots.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected slot request duty=%0d slots=%0d end=%0b last=%0b",
                     $time, got.duty, got.slot_count, got.frame_end, got.last);
          mismatches++;
        end else begin
          want = owed_slots.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $write("%0t: slot mismatch exp duty=%0d slots=%0d end=%0b last=%0b",
                     $time, want.duty, want.slot_count, want.frame_end, want.last);
              $display(", got duty=%0d slots=%0d end=%0b last=%0b",
                       got.duty, got.slot_count, got.frame_end, got.last);
            end
            mismatches++;
          end
        end
      end
    end
    slots_owed = owed_slots.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the LED bit encoder testbench: clock, reset, pixel and register
// stimulus, random back-pressure and the verdict. Depends on albe_pkg,
// addressable_led_bit_encoder and led_bit_checker.
`timescale 1ns / 100ps

module tb_top;
  import albe_pkg::*;

  // cycles to let the pipe empty after the last slot request (4 stages, with margin)
  localparam int PIPE_LATENCY = 10;
  // indexes past the register list; writes there must change nothing
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [31:0]           in_tdata;   // pix_index, red, green, blue
  logic                  out_tvalid;
  logic                  out_tready;
  logic [15:0]           out_tdata;  // duty, slot_count
  logic                  out_tuser;  // frame_end
  logic                  out_tlast;

  int mismatches;
  int slots_owed;

  // chance per cycle, in percent, that the sender or the receiver holds off
  int src_idle_pct;
  int sink_idle_pct;
  // mirror of led_count so that frames can be built in index order
  int chain_len;

  always #10 clk = ~clk;

  addressable_led_bit_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  led_bit_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .slots_owed (slots_owed)
  );

  // Receiver: decide tready afresh at every falling edge, one assignment per step.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Offer one pixel request; hold it until the block takes it. tvalid stays
  // high on return so back-to-back requests need no extra assignment.
  task automatic send_pixel(input logic [7:0] idx, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop tvalid, wait for every owed slot request, then let the pipe settle
  // so that a dropped pixel still in flight cannot see a new register value.
  task automatic wait_for_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (slots_owed == 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // One register write per falling edge; the caller lowers cfg_we afterwards.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == REG_LED_COUNT) chain_len = val;
    @(posedge clk);
  endtask

  task automatic release_cfg();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] bright, input logic [7:0] zc,
                           input logic [7:0] oc, input logic [7:0] rs,
                           input logic [7:0] lc);
    write_reg(REG_BRIGHTNESS, bright);
    write_reg(REG_ZERO_CODE, zc);
    write_reg(REG_ONE_CODE, oc);
    write_reg(REG_RESET_SLOTS, rs);
    write_reg(REG_LED_COUNT, lc);
    release_cfg();
  endtask

  // Random pixels: mostly whole frames in index order, some frames cut short,
  // some stray indices anywhere in 0..255. Count only pixels the block keeps.
  task automatic random_traffic(input int kept_target);
    int kept;
    int pick;
    int stop_at;
    int idx;
    kept = 0;
    while (kept < kept_target) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        stop_at = (pick < 70) ? chain_len - 1 : $urandom_range(chain_len - 1);
        for (int i = 0; i <= stop_at; i++)
          send_pixel(8'(i), 8'($urandom), 8'($urandom), 8'($urandom));
        kept += stop_at + 1;
      end else begin
        idx = $urandom_range(255);
        send_pixel(8'(idx), 8'($urandom), 8'($urandom), 8'($urandom));
        if (idx < chain_len) kept++;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    src_idle_pct  = 6;
    sink_idle_pct = 45;
    chain_len     = LED_COUNT_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: brightness 50, chain of 20, 50 reset slots.
    send_pixel(8'd0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd1, 8'h00, 8'h00, 8'h00);
    send_pixel(8'd2, 8'hAA, 8'h55, 8'h0F);
    send_pixel(8'd19, 8'h80, 8'h01, 8'hFE);   // closes the frame
    send_pixel(8'd20, 8'h12, 8'h34, 8'h56);   // just off the chain: drop
    send_pixel(8'd255, 8'hFF, 8'hFF, 8'hFF);  // drop
    wait_for_idle();

    // Full scale, extreme codes, single LED, no reset period: last on bit 24.
    configure(8'd100, 8'd0, 8'd255, 8'd0, 8'd1);
    send_pixel(8'd0, 8'hFF, 8'h00, 8'hFF);
    send_pixel(8'd0, 8'h00, 8'hFF, 8'h00);
    send_pixel(8'd1, 8'hFF, 8'hFF, 8'hFF);    // drop
    wait_for_idle();

    // Brightness writes above 100 are ignored (255 masks to 127); spare
    // indexes do nothing; longest chain and reset period.
    write_reg(REG_BRIGHTNESS, 8'd37);
    write_reg(REG_BRIGHTNESS, 8'd101);
    write_reg(REG_BRIGHTNESS, 8'd255);
    write_reg(REG_SPARE_LO, 8'hFF);
    write_reg(REG_SPARE_HI, 8'h00);
    write_reg(REG_ZERO_CODE, 8'd255);
    write_reg(REG_ONE_CODE, 8'd0);
    write_reg(REG_RESET_SLOTS, 8'd255);
    write_reg(REG_LED_COUNT, 8'd255);
    release_cfg();
    send_pixel(8'd100, 8'hC3, 8'h3C, 8'h99);
    send_pixel(8'd254, 8'd200, 8'd150, 8'd99); // closes the frame
    send_pixel(8'd255, 8'hFF, 8'hFF, 8'hFF);   // drop
    wait_for_idle();

    // Zero brightness: every bit a zero code; one-slot reset period.
    configure(8'd0, 8'd33, 8'd66, 8'd1, 8'd2);
    send_pixel(8'd0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd1, 8'hFF, 8'hFF, 8'hFF);
    wait_for_idle();

    // 0xE4 masks to 100 and is taken; an empty chain drops every pixel.
    write_reg(REG_BRIGHTNESS, 8'hE4);
    write_reg(REG_LED_COUNT, 8'd0);
    release_cfg();
    send_pixel(8'd0, 8'h81, 8'h42, 8'h24);
    send_pixel(8'd255, 8'h81, 8'h42, 8'h24);
    wait_for_idle();

    // Random part: three idling regimes, two register settings in each.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 6;
          sink_idle_pct = 45;
        end
        1: begin
          src_idle_pct  = 45;
          sink_idle_pct = 6;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int setting = 0; setting < 2; setting++) begin
        configure(8'($urandom_range(127)), 8'($urandom), 8'($urandom),
                  ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                  8'($urandom_range(1, 8)));
        random_traffic(14);
        // hold the sender back until every owed slot has drained
        wait_for_idle();
        random_traffic(13);
        wait_for_idle();
      end
    end

    if (mismatches == 0 && slots_owed == 0) begin
      $display("[addressable_led_bit_encoder] OK");
    end else begin
      $display("[addressable_led_bit_encoder] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("[addressable_led_bit_encoder] ERROR");
    $finish;
  end

endmodule

@@ addressable_led_bit_encoder.f @@
hdl/albe_pkg.sv
hdl/albe_scale.sv
hdl/albe_serial.sv
hdl/addressable_led_bit_encoder.sv
tb/led_bit_checker.sv
tb/tb_top.sv
